// File: rtl/core/mer_pkg.sv
// Shared widths and register indexes for the Mandelbrot escape raster unit.
`default_nettype none

package mer_pkg;

  localparam int FRAC_BITS = 28;
  localparam int MAX_SIDE  = 4096;
  localparam int ITER_BITS = 16;
  localparam int CNT_BITS  = $clog2(MAX_SIDE);
  localparam int SIDE_BITS = CNT_BITS + 1;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = ((ITER_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_RE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_IM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_BUDGET  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT = 3'd6;

  localparam logic [30:0]          PIXEL_STEP_RST   = 31'd268435;
  localparam logic [12:0]          ROW_WIDTH_RST    = 13'd256;
  localparam logic [12:0]          FRAME_HEIGHT_RST = 13'd256;
  localparam logic [ITER_BITS-1:0] ITER_BUDGET_RST  = ITER_BITS'(32);
  localparam logic [30:0]          ESCAPE_LIMIT_RST = 31'h4000_0000;

endpackage

`default_nettype wire

// File: rtl/core/mandelbrot_escape_raster_unit.sv
// Top level: raster walker and escape-time iteration around one shared multiplier.
//
// Usage: each request on the s_axis channel (tdata bit 0 = restart) asks for the
// next pixel of the raster; one result comes out on m_axis with the remaining
// iteration count in tdata, end of row on tlast and end of frame on tuser.
// Registers are written on the cfg channel (always ready); the user must write
// them only while the unit is idle, which the block itself does not enforce.
//
// A request runs its iterations (1..iter_budget, or one if iter_budget is 0) and
// its result enters the output register before the next request is taken.
// Each iteration is four steps of the single 32x32 multiplier sequencer:
// update z, square re, square im, check escape (and start the next cross term).
// s_axis_tready is high only while the sequencer is idle.
//
// The result goes into an output register; the next request is accepted while
// it waits. If the receiver stalls, a finished pixel holds in the sequencer
// until the output register frees up.
//
// Reset: synchronous, active high. Registers return to their defaults, the
// raster restarts at the top-left pixel and no result is pending.
`default_nettype none

module mandelbrot_escape_raster_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [mer_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [0] restart
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [mer_pkg::OUT_DATA_W-1:0]         m_axis_tdata,   // [15:0] iter_left
  output logic                                   m_axis_tlast,   // end_of_row
  output logic                                   m_axis_tuser,   // [0] end_of_frame
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mer_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mer_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_SQI  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v[63:31] == '0 || v[63:31] == '1) begin
      return v[31:0];
    end else if (v[63]) begin
      return S32_MIN;
    end else begin
      return S32_MAX;
    end
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] == v[31]) begin
      return v[31:0];
    end else if (v[32]) begin
      return S32_MIN;
    end else begin
      return S32_MAX;
    end
  endfunction

  // configuration registers
  logic [31:0]          start_re;
  logic [31:0]          start_im;
  logic [30:0]          pixel_step;
  logic [12:0]          row_width;
  logic [12:0]          frame_height;
  logic [ITER_BITS-1:0] iter_budget;
  logic [30:0]          escape_limit;

  // raster state
  logic [31:0]         cur_re;
  logic [31:0]         cur_im;
  logic [CNT_BITS-1:0] col_count;
  logic [CNT_BITS-1:0] row_count;
  logic                at_frame_start;

  // iteration datapath
  logic [2:0]           state;
  logic signed [31:0]   zr, zi, sq_re, sq_im;
  logic signed [63:0]   prod;
  logic [ITER_BITS-1:0] left;
  logic [ITER_BITS-1:0] res_left;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_shift, cross_shift;
  logic signed [31:0] sq_new, nr, ni;
  logic signed [31:0] diff_sat, cross_sat;
  logic signed [32:0] sum;
  logic [ITER_BITS-1:0] left_dec;
  logic                 done;
  logic [SIDE_BITS-1:0] w, h;
  logic                 eor, eof;
  logic                 in_take, load;
  logic                 out_load;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign load          = s_axis_tdata[0] || at_frame_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_re     <= '0;
      start_im     <= '0;
      pixel_step   <= PIXEL_STEP_RST;
      row_width    <= ROW_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      iter_budget  <= ITER_BUDGET_RST;
      escape_limit <= ESCAPE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_RE:     start_re     <= cfg_data;
        REG_START_IM:     start_im     <= cfg_data;
        REG_PIXEL_STEP:   pixel_step   <= cfg_data[30:0];
        REG_ROW_WIDTH:    row_width    <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        REG_ITER_BUDGET:  iter_budget  <= cfg_data[ITER_BITS-1:0];
        REG_ESCAPE_LIMIT: escape_limit <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_SQR:  begin mul_a = zr; mul_b = zr; end
      ST_SQI:  begin mul_a = zi; mul_b = zi; end
      default: begin mul_a = zr; mul_b = zi; end
    endcase
  end

  assign prod_shift  = prod >>> FRAC_BITS;
  assign cross_shift = prod >>> (FRAC_BITS - 1);
  assign sq_new      = sat64(prod_shift);
  assign diff_sat    = sat33({sq_re[31], sq_re} - {sq_im[31], sq_im});
  assign nr          = sat33({diff_sat[31], diff_sat} + {cur_re[31], cur_re});
  assign cross_sat   = sat64(cross_shift);
  assign ni          = sat33({cross_sat[31], cross_sat} + {cur_im[31], cur_im});
  assign sum      = {sq_re[31], sq_re} + {sq_new[31], sq_new};
  assign left_dec = left - ITER_BITS'(1);
  assign done     = (left_dec == '0) || (sum >= $signed({2'b00, escape_limit}));
  assign out_load = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  // clamp geometry to 1..MAX_SIDE
  always_comb begin
    if (row_width == '0) begin
      w = SIDE_BITS'(1);
    end else if (row_width > 13'(MAX_SIDE)) begin
      w = SIDE_BITS'(MAX_SIDE);
    end else begin
      w = row_width[SIDE_BITS-1:0];
    end
    if (frame_height == '0) begin
      h = SIDE_BITS'(1);
    end else if (frame_height > 13'(MAX_SIDE)) begin
      h = SIDE_BITS'(MAX_SIDE);
    end else begin
      h = frame_height[SIDE_BITS-1:0];
    end
  end

  assign eor = ({1'b0, col_count} + SIDE_BITS'(1)) >= w;
  assign eof = eor && (({1'b0, row_count} + SIDE_BITS'(1)) >= h);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      at_frame_start <= 1'b1;
      cur_re         <= '0;
      cur_im         <= '0;
      col_count      <= '0;
      row_count      <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (load) begin
              cur_re         <= start_re;
              cur_im         <= start_im;
              col_count      <= '0;
              row_count      <= '0;
              at_frame_start <= 1'b0;
            end
            zr    <= '0;
            zi    <= '0;
            sq_re <= '0;
            sq_im <= '0;
            prod  <= '0;
            left  <= (iter_budget == '0) ? ITER_BITS'(1) : iter_budget;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          zr    <= nr;
          zi    <= ni;
          state <= ST_SQR;
        end
        ST_SQR: begin
          prod  <= mul_a * mul_b;
          state <= ST_SQI;
        end
        ST_SQI: begin
          sq_re <= sq_new;
          prod  <= mul_a * mul_b;
          state <= ST_CHK;
        end
        ST_CHK: begin
          sq_im    <= sq_new;
          prod     <= mul_a * mul_b;
          left     <= left_dec;
          res_left <= left_dec;
          state    <= done ? ST_OUT : ST_UPD;
        end
        ST_OUT: begin
          if (out_load) begin
            m_axis_tdata  <= OUT_DATA_W'(res_left);
            m_axis_tlast  <= eor;
            m_axis_tuser  <= eof;
            if (eof) begin
              at_frame_start <= 1'b1;
              col_count      <= '0;
              row_count      <= '0;
            end else if (eor) begin
              col_count <= '0;
              row_count <= row_count + CNT_BITS'(1);
              cur_re    <= start_re;
              cur_im    <= cur_im + {1'b0, pixel_step};
            end else begin
              col_count <= col_count + CNT_BITS'(1);
              cur_re    <= cur_re + {1'b0, pixel_step};
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mer_checker.sv
// Port-level assertions for the Mandelbrot escape raster unit, bound to the top level.
`default_nettype none

module mer_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tlast,
  input wire logic                          m_axis_tuser
);
  import mer_pkg::*;

  // a request makes the sequencer busy in the cycle after it is accepted
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a request");

  // end of frame is always also end of row
  a_eof_is_eor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end of frame without end of row");

  // nothing pending after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind mandelbrot_escape_raster_unit mer_checker u_mer_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
